FILE: src/swam_pkg.sv
`default_nettype none

package swam_pkg;

   localparam int LETTER_W = 5;
   localparam int LETTER_CODES = 2 ** LETTER_W;
   localparam int BALANCE_W = 8;

   typedef enum logic {
      OP_PATTERN = 1'b0,
      OP_TEXT    = 1'b1
   } op_type;

   typedef logic [BALANCE_W-1:0] balance_type;

endpackage

`default_nettype wire

FILE: src/sliding_window_anagram_match_core.sv
// Streaming anagram matcher. Pattern letters (req_op low) build up a letter
// multiset; text letters (req_op high) slide a window of pattern length over
// the text, and each text transfer reports whether that window is a
// permutation of the pattern. Setting req_restart on a transfer clears all
// state before the item is applied.
// Both channels use valid and stall: a transfer happens at a rising clock
// edge with valid high and stall low. Every input transfer gives exactly one
// result transfer carrying rsp_match, the sticky rsp_found (also high while
// the pattern is empty) and the sticky rsp_overflow.
// The item waits in the input register, where the departing window letter
// arrives from the history memory; then the updated balances and flags are
// written into the result register. Throughput is one item per cycle while
// rsp_stall is low; the history memory read for the next item is issued
// from the next-state values and bypasses a same-cycle write.
// Synchronous reset clears the balances, counters, flags and both valid
// registers. When rsp_stall is high the result is held, one more item is
// taken into the input register, and req_stall then rises until the result
// transfer completes.
`default_nettype none

module sliding_window_anagram_match_core #(
   parameter int MAX_PATTERN = 64,
   parameter int ALPHABET = 26
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic                          req_restart,
   input  wire logic [swam_pkg::LETTER_W-1:0] req_letter,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_match,
   output logic                               rsp_found,
   output logic                               rsp_overflow
);

   localparam int IW = (ALPHABET >= swam_pkg::LETTER_CODES) ? swam_pkg::LETTER_W
                                                           : $clog2(ALPHABET);
   localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int SW = CW + 1;
   localparam int NW = $clog2(ALPHABET + 1);
   localparam int BW = swam_pkg::BALANCE_W;

   logic [IW-1:0] fold_table [swam_pkg::LETTER_CODES];

   for (genvar v = 0; v < swam_pkg::LETTER_CODES; v++) begin : g_fold
      localparam int FOLDED = v % ALPHABET;
      assign fold_table[v] = IW'(FOLDED);
   end

   logic             in_valid_ff;
   swam_pkg::op_type in_op_ff;
   logic             in_restart_ff;
   logic [IW-1:0]    in_letter_ff;
   logic [IW-1:0]    leave_ff;

   logic out_valid_ff;
   logic out_match_ff;
   logic out_found_ff;
   logic out_overflow_ff;

   swam_pkg::balance_type bal_ff [ALPHABET];
   swam_pkg::balance_type bal_in [ALPHABET];
   logic [CW-1:0]         len_ff, len_in;
   logic [CW-1:0]         seen_ff, seen_in;
   logic [AW-1:0]         slot_ff, slot_in;
   logic [NW-1:0]         nonzero_ff, nonzero_in;
   logic                  found_ff, found_in;
   logic                  overflow_ff, overflow_in;

   logic [IW-1:0] recent_mem [MAX_PATTERN];

   logic advance;
   logic accept;

   logic          is_text;
   logic [CW-1:0] len_base, seen_base;
   logic [AW-1:0] slot_base;
   logic [NW-1:0] nonzero_base;
   logic          pat_take, pat_drop, evict, same_letter;
   logic [IW-1:0] leave_letter;

   logic [ALPHABET-1:0]   inc_vec, dec_vec, zero_vec, ones_vec, one_vec;
   swam_pkg::balance_type bal_base [ALPHABET];
   swam_pkg::balance_type bal_upd [ALPHABET];
   logic                  inc_rise, dec_rise, inc_fall, dec_fall;

   logic [CW-1:0] len_upd, seen_upd;
   logic [AW-1:0] slot_upd;
   logic [NW-1:0] nonzero_upd;
   logic          match_upd, found_upd, overflow_upd;

   logic [SW-1:0] slot_ext, len_ext, back_sum;
   logic [AW-1:0] rd_addr;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign is_text      = (in_op_ff == swam_pkg::OP_TEXT);
   assign len_base     = in_restart_ff ? '0 : len_ff;
   assign seen_base    = in_restart_ff ? '0 : seen_ff;
   assign slot_base    = in_restart_ff ? '0 : slot_ff;
   assign nonzero_base = in_restart_ff ? '0 : nonzero_ff;

   assign pat_take = !is_text && (seen_base == '0) && (len_base < CW'(MAX_PATTERN));
   assign pat_drop = !is_text && (seen_base == '0) && (len_base >= CW'(MAX_PATTERN));
   assign evict    = is_text && ((len_base == '0) || (seen_base >= len_base));
   assign leave_letter = (len_base == '0) ? in_letter_ff : leave_ff;
   assign same_letter  = evict && (leave_letter == in_letter_ff);

   always_comb begin
      for (int i = 0; i < ALPHABET; i++) begin
         bal_base[i] = in_restart_ff ? '0 : bal_ff[i];
         inc_vec[i]  = (pat_take && (in_letter_ff == IW'(i))) ||
                       (evict && !same_letter && (leave_letter == IW'(i)));
         dec_vec[i]  = is_text && !same_letter && (in_letter_ff == IW'(i));
         zero_vec[i] = (bal_base[i] == '0);
         ones_vec[i] = (bal_base[i] == '1);
         one_vec[i]  = (bal_base[i] == BW'(1));
         if (inc_vec[i]) begin
            bal_upd[i] = bal_base[i] + BW'(1);
         end else if (dec_vec[i]) begin
            bal_upd[i] = bal_base[i] - BW'(1);
         end else begin
            bal_upd[i] = bal_base[i];
         end
      end
   end

   assign inc_rise = |(inc_vec & zero_vec);
   assign dec_rise = |(dec_vec & zero_vec);
   assign inc_fall = |(inc_vec & ones_vec);
   assign dec_fall = |(dec_vec & one_vec);

   assign nonzero_upd = nonzero_base + NW'(inc_rise) + NW'(dec_rise)
                        - NW'(inc_fall) - NW'(dec_fall);
   assign match_upd    = is_text && (nonzero_upd == '0);
   assign found_upd    = (in_restart_ff ? 1'b0 : found_ff) | match_upd;
   assign overflow_upd = (in_restart_ff ? 1'b0 : overflow_ff) | pat_drop;
   assign len_upd      = pat_take ? len_base + CW'(1) : len_base;
   assign seen_upd     = (is_text && (seen_base < CW'(MAX_PATTERN))) ? seen_base + CW'(1)
                                                                    : seen_base;

   always_comb begin
      if (!is_text) begin
         slot_upd = slot_base;
      end else if (slot_base == AW'(MAX_PATTERN - 1)) begin
         slot_upd = '0;
      end else begin
         slot_upd = slot_base + AW'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < ALPHABET; i++) begin
         bal_in[i] = advance ? bal_upd[i] : bal_ff[i];
      end
      len_in      = advance ? len_upd : len_ff;
      seen_in     = advance ? seen_upd : seen_ff;
      slot_in     = advance ? slot_upd : slot_ff;
      nonzero_in  = advance ? nonzero_upd : nonzero_ff;
      found_in    = advance ? found_upd : found_ff;
      overflow_in = advance ? overflow_upd : overflow_ff;
   end

   // The next item's departing letter sits pattern_length slots behind the
   // write slot that holds once the current item has been applied.
   assign slot_ext = SW'(slot_in);
   assign len_ext  = SW'(len_in);
   always_comb begin
      if (slot_ext >= len_ext) begin
         back_sum = slot_ext - len_ext;
      end else begin
         back_sum = slot_ext + SW'(MAX_PATTERN) - len_ext;
      end
   end
   assign rd_addr = back_sum[AW-1:0];

   always_ff @(posedge clock) begin
      if (advance && is_text) begin
         recent_mem[slot_base] <= in_letter_ff;
      end
      if (accept) begin
         if (advance && is_text && (slot_base == rd_addr)) begin
            leave_ff <= in_letter_ff;
         end else begin
            leave_ff <= recent_mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff      <= swam_pkg::op_type'(req_op);
         in_restart_ff <= req_restart;
         in_letter_ff  <= fold_table[req_letter];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHABET; i++) begin
            bal_ff[i] <= '0;
         end
         len_ff      <= '0;
         seen_ff     <= '0;
         slot_ff     <= '0;
         nonzero_ff  <= '0;
         found_ff    <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         for (int i = 0; i < ALPHABET; i++) begin
            bal_ff[i] <= bal_in[i];
         end
         len_ff      <= len_in;
         seen_ff     <= seen_in;
         slot_ff     <= slot_in;
         nonzero_ff  <= nonzero_in;
         found_ff    <= found_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_match_ff    <= match_upd;
         out_found_ff    <= found_upd | (len_upd == '0);
         out_overflow_ff <= overflow_upd;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_match    = out_match_ff;
   assign rsp_found    = out_found_ff;
   assign rsp_overflow = out_overflow_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_match || rsp_found))
      else $error("A matching window was reported without the found flag.");

   assert property (@(posedge clock) disable iff (reset)
      (overflow_ff && !(advance && in_restart_ff)) |=> overflow_ff)
      else $error("The overflow flag cleared without a restart.");

   assert property (@(posedge clock) disable iff (reset)
      (len_ff <= CW'(MAX_PATTERN)) && (seen_ff <= CW'(MAX_PATTERN)))
      else $error("Pattern length or text count exceeds the window depth.");

   assert property (@(posedge clock) disable iff (reset)
      (advance && !is_text) |=> $stable(slot_ff) || $past(in_restart_ff))
      else $error("A pattern letter moved the history write slot.");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_sliding_window_anagram_match_core.sv
`timescale 1ns / 100ps

module tb_sliding_window_anagram_match_core;

   localparam int MAX_PATTERN = 64;
   localparam int ALPHABET = 26;
   localparam int LETTER_W = swam_pkg::LETTER_W;
   localparam int ITEM_TARGET = 1650;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      swam_pkg::op_type    op;
      logic                restart;
      logic [LETTER_W-1:0] letter;
      logic                hold;
   } letter_item_type;

   typedef struct packed {
      logic match;
      logic found;
      logic overflow;
   } window_verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = swam_pkg::OP_PATTERN;
   logic                req_restart = 1'b0;
   logic [LETTER_W-1:0] req_letter = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_match;
   logic                rsp_found;
   logic                rsp_overflow;

   swam_pkg::balance_type balance [ALPHABET];
   logic [LETTER_W-1:0]   text_history [MAX_PATTERN];
   int                    pattern_len;
   int                    text_count;
   int                    history_slot;
   int                    unbalanced_letters;
   logic                  found_sticky;
   logic                  overflow_sticky;

   letter_item_type     pending_items [$];
   window_verdict_type  expected_verdicts [$];
   int                  queued_items = 0;
   int                  offered_total = 0;
   int                  accepted_total = 0;
   int                  send_gap = 0;
   int                  stall_left = 0;
   bit                  draining = 1'b0;
   bit                  quiet = 1'b0;
   int                  cycle_count = 0;
   int                  fail_count = 0;

   sliding_window_anagram_match_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_restart  (req_restart),
      .req_letter   (req_letter),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_match    (rsp_match),
      .rsp_found    (rsp_found),
      .rsp_overflow (rsp_overflow)
   );

   always #1 clock = ~clock;

   function automatic void clear_matcher();
      for (int i = 0; i < ALPHABET; i++) begin
         balance[i] = '0;
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         text_history[i] = '0;
      end
      pattern_len = 0;
      text_count = 0;
      history_slot = 0;
      unbalanced_letters = 0;
      found_sticky = 1'b0;
      overflow_sticky = 1'b0;
   endfunction

   function automatic void shift_balance(int c, bit up);
      swam_pkg::balance_type old_count;
      swam_pkg::balance_type new_count;
      old_count = balance[c];
      new_count = up ? old_count + 1'b1 : old_count - 1'b1;
      balance[c] = new_count;
      if (old_count == 0 && new_count != 0) begin
         unbalanced_letters++;
      end else if (old_count != 0 && new_count == 0) begin
         unbalanced_letters--;
      end
   endfunction

   function automatic window_verdict_type predict_window(letter_item_type it);
      window_verdict_type v;
      int                 c;
      int                 leaving;
      int                 idx;
      bit                 evict;
      c = int'(it.letter) % ALPHABET;
      leaving = c;
      evict = 1'b0;
      v.match = 1'b0;
      if (it.restart) begin
         clear_matcher();
      end
      if (it.op == swam_pkg::OP_PATTERN) begin
         if (text_count == 0) begin
            if (pattern_len >= MAX_PATTERN) begin
               overflow_sticky = 1'b1;
            end else begin
               shift_balance(c, 1'b1);
               pattern_len++;
            end
         end
      end else begin
         if (pattern_len == 0) begin
            evict = 1'b1;
         end else if (text_count >= pattern_len) begin
            idx = (history_slot >= pattern_len) ? history_slot - pattern_len
                                                : history_slot + MAX_PATTERN - pattern_len;
            leaving = int'(text_history[idx % MAX_PATTERN]) % ALPHABET;
            evict = 1'b1;
         end
         text_history[history_slot] = LETTER_W'(c);
         history_slot = (history_slot + 1 >= MAX_PATTERN) ? 0 : history_slot + 1;
         shift_balance(c, 1'b0);
         if (evict) begin
            shift_balance(leaving, 1'b1);
         end
         if (text_count < MAX_PATTERN) begin
            text_count++;
         end
         if (unbalanced_letters == 0) begin
            v.match = 1'b1;
            found_sticky = 1'b1;
         end
      end
      v.found = found_sticky | (pattern_len == 0);
      v.overflow = overflow_sticky;
      return v;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      if (r < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_letter(swam_pkg::op_type kind, logic restart, int letter);
      letter_item_type item;
      item = '{op: kind, restart: restart, letter: LETTER_W'(letter), hold: 1'b0};
      pending_items.insert(pending_items.size(), item);
      queued_items++;
   endfunction

   function automatic void add_hold();
      letter_item_type item;
      item = '{op: swam_pkg::OP_PATTERN, restart: 1'b0, letter: '0, hold: 1'b1};
      pending_items.insert(pending_items.size(), item);
   endfunction

   // A well-formed sequence: restart, a pattern, then text that is mostly made of
   // shuffled copies and letters of the pattern so that windows match often.
   function automatic void add_sequence(int pat_len);
      int pattern_letters [$];
      int shuffled [$];
      int span;
      int text_len;
      int sent;
      int r;
      int j;
      int tmp;
      span = $urandom_range(0, 1) ? 3 : 31;
      for (int i = 0; i < pat_len; i++) begin
         r = $urandom_range(0, span);
         add_letter(swam_pkg::OP_PATTERN, i == 0, r);
         if (i < MAX_PATTERN) begin
            pattern_letters.insert(pattern_letters.size(), r);
         end
      end
      text_len = $urandom_range(1, 2 * pat_len + 10);
      sent = 0;
      while (sent < text_len) begin
         r = $urandom_range(0, 99);
         if (r < 40 && pattern_letters.size() > 0) begin
            shuffled = pattern_letters;
            for (int i = shuffled.size() - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = shuffled[i];
               shuffled[i] = shuffled[j];
               shuffled[j] = tmp;
            end
            foreach (shuffled[i]) begin
               add_letter(swam_pkg::OP_TEXT, pat_len == 0 && sent == 0, shuffled[i]);
               sent++;
            end
         end else if (r < 70 && pattern_letters.size() > 0) begin
            add_letter(swam_pkg::OP_TEXT, 1'b0,
                       pattern_letters[$urandom_range(0, pattern_letters.size() - 1)]);
            sent++;
         end else if (r < 96) begin
            add_letter(swam_pkg::OP_TEXT, pat_len == 0 && sent == 0,
                       $urandom_range(0, span));
            sent++;
         end else begin
            add_letter(swam_pkg::OP_PATTERN, 1'b0, $urandom_range(0, 31));
         end
      end
   endfunction

   function automatic void add_noise(int count);
      for (int i = 0; i < count; i++) begin
         add_letter(swam_pkg::op_type'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 31));
      end
   endfunction

   task automatic report_field(string field, logic want, logic got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0b, got %0b", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      letter_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (offered_total == accepted_total) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (draining) begin
            draining = (expected_verdicts.size() != 0);
            req_valid <= 1'b0;
         end else if (pending_items.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            next_item = pending_items.pop_front();
            if (next_item.hold) begin
               draining = 1'b1;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_op <= next_item.op;
               req_restart <= next_item.restart;
               req_letter <= next_item.letter;
               offered_total++;
               send_gap = pick_gap();
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) begin
            stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      window_verdict_type want;
      letter_item_type    taken;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result transfer: match=%0b found=%0b overflow=%0b",
                        $time, rsp_match, rsp_found, rsp_overflow);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               report_field("match", want.match, rsp_match);
               report_field("found", want.found, rsp_found);
               report_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_valid && !req_stall) begin
            taken = '{op: swam_pkg::op_type'(req_op), restart: req_restart,
                      letter: req_letter, hold: 1'b0};
            expected_verdicts.insert(expected_verdicts.size(), predict_window(taken));
            accepted_total++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 300 == 0) begin
         quiet = ($urandom_range(0, 3) == 0);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sliding_window_anagram_match_core test failed");
         $finish;
      end
   end

   initial begin
      int r;
      clear_matcher();

      // Empty pattern, a two-letter pattern, letters that wrap, a pattern letter
      // after text, and a restart carried on a text letter.
      add_letter(swam_pkg::OP_TEXT, 1'b0, 0);
      add_letter(swam_pkg::OP_PATTERN, 1'b1, 0);
      add_letter(swam_pkg::OP_PATTERN, 1'b0, 25);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 25);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 0);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 0);
      add_letter(swam_pkg::OP_PATTERN, 1'b0, 3);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 26);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 25);
      add_letter(swam_pkg::OP_TEXT, 1'b1, 31);
      add_letter(swam_pkg::OP_PATTERN, 1'b1, 31);
      add_letter(swam_pkg::OP_PATTERN, 1'b0, 30);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 4);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 5);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 15);
      add_letter(swam_pkg::OP_TEXT, 1'b0, 16);
      add_hold();

      add_sequence(MAX_PATTERN + 2);
      while (queued_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            add_noise($urandom_range(1, 10));
         end else if (r < 12) begin
            add_sequence(0);
         end else if (r < 85) begin
            add_sequence($urandom_range(1, 6));
         end else if (r < 97) begin
            add_sequence($urandom_range(7, 20));
         end else begin
            add_sequence($urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 6));
         end
         if ($urandom_range(0, 99) < 2) begin
            add_hold();
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || offered_total != accepted_total || draining ||
             expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_verdicts.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_verdicts.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("sliding_window_anagram_match_core test passed");
      end else begin
         $display("sliding_window_anagram_match_core test failed");
      end
      $finish;
   end

endmodule

FILE: sliding_window_anagram_match_core.f
src/swam_pkg.sv
src/sliding_window_anagram_match_core.sv
verif/tb_sliding_window_anagram_match_core.sv
